FILE: sv/edu_pkg.sv
// ----------------------------------------------------------------------------
// edu_pkg: shared definitions for the Euclidean distance unit
// Widths, register map and inter-stage bus types used across the design.
// ----------------------------------------------------------------------------
package edu_pkg;

  localparam int MaxDims   = 4;
  localparam int LaneSlots = 4;
  localparam int CoordW    = 16;
  localparam int DiffW     = CoordW + 1;
  localparam int MagW      = CoordW;
  localparam int SqW       = 2 * MagW;
  localparam int PairW     = SqW + 1;
  localparam int SumW      = SqW + 2;
  localparam int ResW      = 17;
  localparam int RootSteps = SumW / 2;
  localparam int RemW      = ResW + 1;
  localparam int TrialW    = RemW + 2;
  localparam int DimsW     = 3;
  localparam int DataW     = 32;
  localparam int PaddrW    = 3;

  localparam logic [0:0]       RegActiveDims   = 1'b0;
  localparam logic [DimsW-1:0] ActiveDimsReset = 3'd4;
  localparam logic [ResW-1:0]  ResMax          = 17'd131070;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [SqW-1:0]           sq_t;

  typedef struct packed {
    logic                  valid;
    sq_t [MaxDims-1:0]     sq;
  } sq_bus_t;

  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
  } sum_bus_t;

endpackage

FILE: sv/edu_if.sv
// ----------------------------------------------------------------------------
// edu_if: stream channels of the Euclidean distance unit
// Point-pair request channel and distance result channel, valid/ready.
// ----------------------------------------------------------------------------
interface edu_in_if;
  logic           valid;
  logic           ready;
  edu_pkg::coord_t a_coord0;
  edu_pkg::coord_t a_coord1;
  edu_pkg::coord_t a_coord2;
  edu_pkg::coord_t a_coord3;
  edu_pkg::coord_t b_coord0;
  edu_pkg::coord_t b_coord1;
  edu_pkg::coord_t b_coord2;
  edu_pkg::coord_t b_coord3;

  modport source (
    output valid, a_coord0, a_coord1, a_coord2, a_coord3,
    output b_coord0, b_coord1, b_coord2, b_coord3,
    input  ready
  );
  modport sink (
    input  valid, a_coord0, a_coord1, a_coord2, a_coord3,
    input  b_coord0, b_coord1, b_coord2, b_coord3,
    output ready
  );
endinterface

interface edu_out_if;
  logic                        valid;
  logic                        ready;
  logic [edu_pkg::ResW-1:0]    dist_res;

  modport source (
    output valid, dist_res,
    input  ready
  );
  modport sink (
    input  valid, dist_res,
    output ready
  );
endinterface

FILE: sv/edu_lane.sv
// ----------------------------------------------------------------------------
// edu_lane: one coordinate lane
// Forms the exact difference, its magnitude and the registered square.
// ----------------------------------------------------------------------------
module edu_lane (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            act_i,
  input  edu_pkg::coord_t a_i,
  input  edu_pkg::coord_t b_i,
  output edu_pkg::sq_t    sq_o
);
  import edu_pkg::*;

  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag_full;
  logic [MagW-1:0]         mag;
  sq_t                     sq_d, sq_q;

  assign diff     = DiffW'(a_i) - DiffW'(b_i);
  assign mag_full = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign mag      = mag_full[MagW-1:0];
  assign sq_d     = act_i ? (SqW'(mag) * SqW'(mag)) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

FILE: sv/edu_merge.sv
// ----------------------------------------------------------------------------
// edu_merge: lane merge
// Two-level registered adder tree over the lane squares.
// ----------------------------------------------------------------------------
module edu_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  edu_pkg::sq_bus_t  sq_i,
  output logic              ready_o,
  output edu_pkg::sum_bus_t sum_o,
  input  logic              ready_i
);
  import edu_pkg::*;

  sq_t              sq4 [LaneSlots];
  logic             va_q, vb_q;
  logic             rdy_a, rdy_b;
  logic [PairW-1:0] pair_q [2];
  logic [SumW-1:0]  sum_q;

  for (genvar i = 0; i < LaneSlots; i++) begin : g_pad
    if (i < MaxDims) begin : g_used
      assign sq4[i] = sq_i.sq[i];
    end else begin : g_zero
      assign sq4[i] = '0;
    end
  end

  assign rdy_b = !vb_q || ready_i;
  assign rdy_a = !va_q || rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= sq_i.valid;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      pair_q[0] <= PairW'(sq4[0]) + PairW'(sq4[1]);
      pair_q[1] <= PairW'(sq4[2]) + PairW'(sq4[3]);
    end
    if (rdy_b) begin
      sum_q <= SumW'(pair_q[0]) + SumW'(pair_q[1]);
    end
  end

  assign ready_o     = rdy_a;
  assign sum_o.valid = vb_q;
  assign sum_o.sum   = sum_q;

endmodule

FILE: sv/edu_isqrt.sv
// ----------------------------------------------------------------------------
// edu_isqrt: pipelined floor square root
// One root bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module edu_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  edu_pkg::sum_bus_t        sum_i,
  output logic                     ready_o,
  output logic                     valid_o,
  output logic [edu_pkg::ResW-1:0] root_o,
  input  logic                     ready_i
);
  import edu_pkg::*;

  logic            v_q    [RootSteps];
  logic            rdy    [RootSteps];
  logic [ResW-1:0] root_q [RootSteps];
  logic [RemW-1:0] rem_q  [RootSteps-1];
  logic [SumW-1:0] n_q    [RootSteps-1];

  for (genvar j = 0; j < RootSteps; j++) begin : g_stage
    logic              v_in;
    logic [ResW-1:0]   root_in;
    logic [RemW-1:0]   rem_in;
    logic [SumW-1:0]   n_in;
    logic [TrialW-1:0] rem_new, trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign v_in    = sum_i.valid;
      assign root_in = '0;
      assign rem_in  = '0;
      assign n_in    = sum_i.sum;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign root_in = root_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign n_in    = n_q[j-1];
    end

    if (j == RootSteps - 1) begin : g_last_rdy
      assign rdy[j] = !v_q[j] || ready_i;
    end else begin : g_mid_rdy
      assign rdy[j] = !v_q[j] || rdy[j+1];
    end

    assign rem_new = {rem_in, n_in[SumW-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign ge      = rem_new >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        root_q[j] <= {root_in[ResW-2:0], ge};
      end
    end

    if (j < RootSteps - 1) begin : g_carry
      logic [TrialW-1:0] rem_sub;

      assign rem_sub = rem_new - trial;

      always_ff @(posedge clk_i) begin
        if (rdy[j]) begin
          rem_q[j] <= ge ? rem_sub[RemW-1:0] : rem_new[RemW-1:0];
          n_q[j]   <= {n_in[SumW-3:0], 2'b00};
        end
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[RootSteps-1];
  assign root_o  = root_q[RootSteps-1];

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[RootSteps-2] |-> rem_q[RootSteps-2] <= {root_q[RootSteps-2], 1'b0})
    else $error("partial remainder exceeds twice the partial root");
`endif

endmodule

FILE: sv/euclidean_distance_unit_core.sv
// ----------------------------------------------------------------------------
// euclidean_distance_unit_core: Euclidean distance of two Q8.8 points
// Four coordinate lanes, registered merge tree and pipelined square root.
// ----------------------------------------------------------------------------
// One point pair is taken every clock cycle unless the pipeline stalls, and its
// distance passes the lane square registers, the registered adder tree and the
// square root, which extracts one result bit per stage. Every stage has its own
// valid and ready, so a stalled result only holds back the stages behind it
// that are full. The active_dims register (offset 0, reset 4) selects how many
// lanes count; zero counts as one and values above four as four. For a vector
// length drive the second point with zeros.
module euclidean_distance_unit_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  edu_in_if.sink                     in_i,
  edu_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edu_pkg::PaddrW-1:0] paddr,
  input  logic [edu_pkg::DataW-1:0]  pwdata,
  output logic [edu_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import edu_pkg::*;

  logic [DimsW-1:0] dims_q, dims_d;
  logic [DimsW-1:0] eff_dims;
  logic             cfg_wr;
  coord_t           a_c [LaneSlots];
  coord_t           b_c [LaneSlots];
  logic             v0_q;
  logic             rdy0;
  logic             mrg_rdy;
  logic             sqr_rdy;
  sq_bus_t          sq_bus;
  sum_bus_t         sum_bus;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegActiveDims);
  assign dims_d = cfg_wr ? pwdata[DimsW-1:0] : dims_q;
  assign prdata = (paddr[2] == RegActiveDims) ? DataW'(dims_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= ActiveDimsReset;
    end else begin
      dims_q <= dims_d;
    end
  end

  always_comb begin
    eff_dims = dims_q;
    if (dims_q == '0) begin
      eff_dims = DimsW'(1);
    end else if (dims_q > DimsW'(MaxDims)) begin
      eff_dims = DimsW'(MaxDims);
    end
  end

  assign a_c[0] = in_i.a_coord0;
  assign a_c[1] = in_i.a_coord1;
  assign a_c[2] = in_i.a_coord2;
  assign a_c[3] = in_i.a_coord3;
  assign b_c[0] = in_i.b_coord0;
  assign b_c[1] = in_i.b_coord1;
  assign b_c[2] = in_i.b_coord2;
  assign b_c[3] = in_i.b_coord3;

  // lane stage
  assign rdy0       = !v0_q || mrg_rdy;
  assign in_i.ready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_i.valid;
    end
  end

  for (genvar i = 0; i < MaxDims; i++) begin : g_lane
    edu_lane u_lane (
      .clk_i (clk_i),
      .en_i  (rdy0),
      .act_i (DimsW'(i) < eff_dims),
      .a_i   (a_c[i]),
      .b_i   (b_c[i]),
      .sq_o  (sq_bus.sq[i])
    );
  end

  assign sq_bus.valid = v0_q;

  edu_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sq_i    (sq_bus),
    .ready_o (mrg_rdy),
    .sum_o   (sum_bus),
    .ready_i (sqr_rdy)
  );

  edu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sum_i   (sum_bus),
    .ready_o (sqr_rdy),
    .valid_o (out_o.valid),
    .root_o  (out_o.dist_res),
    .ready_i (out_o.ready)
  );

`ifndef SYNTHESIS
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with an empty output stage");

  a_dims_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eff_dims != '0) && (eff_dims <= DimsW'(MaxDims)))
    else $error("effective lane count out of range");

  a_res_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.dist_res <= ResMax)
    else $error("distance exceeds largest reachable value");
`endif

endmodule
